// ----- rtl/kst_pkg.sv -----
package kst_pkg;

  localparam int CMD_QUEUE_DEPTH = 32;

  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = 2;
  localparam int RES_CNT_W = 3;

  localparam logic [7:0] BYTE_SET_LEDS = 8'hed;
  localparam logic [7:0] BYTE_ACK      = 8'hfa;
  localparam logic [7:0] BYTE_RESEND   = 8'hfe;

  localparam logic [7:0] SC_ESCAPE     = 8'h01;
  localparam logic [7:0] SC_BACKSPACE  = 8'h0e;
  localparam logic [7:0] SC_TAB        = 8'h0f;
  localparam logic [7:0] SC_ENTER      = 8'h1c;
  localparam logic [7:0] SC_CTRL       = 8'h1d;
  localparam logic [7:0] SC_LSHIFT     = 8'h2a;
  localparam logic [7:0] SC_RSHIFT     = 8'h36;
  localparam logic [7:0] SC_ALT        = 8'h38;
  localparam logic [7:0] SC_CAPS       = 8'h3a;
  localparam logic [7:0] SC_NUM        = 8'h45;
  localparam logic [7:0] SC_SCROLL     = 8'h46;
  localparam logic [7:0] SC_CTRL_UP    = 8'h9d;
  localparam logic [7:0] SC_LSHIFT_UP  = 8'haa;
  localparam logic [7:0] SC_C_UP       = 8'hae;
  localparam logic [7:0] SC_RSHIFT_UP  = 8'hb6;
  localparam logic [7:0] SC_ALT_UP     = 8'hb8;

  localparam logic [7:0] CHAR_LF       = 8'h0a;
  localparam logic [7:0] CHAR_BS       = 8'h08;
  localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z  = 8'h5a;
  localparam logic [7:0] CASE_GAP      = 8'h20;

  localparam logic [2:0] KIND_CHAR     = 3'd0;
  localparam logic [2:0] KIND_KBD      = 3'd1;
  localparam logic [2:0] KIND_BREAK    = 3'd2;
  localparam logic [2:0] KIND_SWITCH   = 3'd3;
  localparam logic [2:0] KIND_ESCAPE   = 3'd4;

  localparam logic ITEM_SCAN = 1'b0;
  localparam logic ITEM_IDLE = 1'b1;

  localparam logic REG_BOOT_LEDS   = 1'b0;
  localparam logic REG_RETRY_LIMIT = 1'b1;

  localparam logic [2:0] LED_CAPS   = 3'b100;
  localparam logic [2:0] LED_NUM    = 3'b010;
  localparam logic [2:0] LED_SCROLL = 3'b001;

  localparam logic [3:0] RETRY_LIMIT_RESET = 4'd5;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic       last;
  } res_t;

  function automatic logic [7:0] plain_char(input logic [6:0] code);
    logic [7:0] c;
    case (code)
      7'h02: c = 8'h31;
      7'h03: c = 8'h32;
      7'h04: c = 8'h33;
      7'h05: c = 8'h34;
      7'h06: c = 8'h35;
      7'h07: c = 8'h36;
      7'h08: c = 8'h37;
      7'h09: c = 8'h38;
      7'h0a: c = 8'h39;
      7'h0b: c = 8'h30;
      7'h0c: c = 8'h2d;
      7'h0d: c = 8'h3d;
      7'h10: c = 8'h51;
      7'h11: c = 8'h57;
      7'h12: c = 8'h45;
      7'h13: c = 8'h52;
      7'h14: c = 8'h54;
      7'h15: c = 8'h59;
      7'h16: c = 8'h55;
      7'h17: c = 8'h49;
      7'h18: c = 8'h4f;
      7'h19: c = 8'h50;
      7'h1a: c = 8'h5b;
      7'h1b: c = 8'h5d;
      7'h1e: c = 8'h41;
      7'h1f: c = 8'h53;
      7'h20: c = 8'h44;
      7'h21: c = 8'h46;
      7'h22: c = 8'h47;
      7'h23: c = 8'h48;
      7'h24: c = 8'h4a;
      7'h25: c = 8'h4b;
      7'h26: c = 8'h4c;
      7'h27: c = 8'h3b;
      7'h28: c = 8'h27;
      7'h2b: c = 8'h5c;
      7'h2c: c = 8'h5a;
      7'h2d: c = 8'h58;
      7'h2e: c = 8'h43;
      7'h2f: c = 8'h56;
      7'h30: c = 8'h42;
      7'h31: c = 8'h4e;
      7'h32: c = 8'h4d;
      7'h33: c = 8'h2c;
      7'h34: c = 8'h2e;
      7'h35: c = 8'h2f;
      7'h37: c = 8'h2a;
      7'h39: c = 8'h20;
      7'h47: c = 8'h37;
      7'h48: c = 8'h38;
      7'h49: c = 8'h39;
      7'h4a: c = 8'h2d;
      7'h4b: c = 8'h34;
      7'h4c: c = 8'h35;
      7'h4d: c = 8'h36;
      7'h4e: c = 8'h2b;
      7'h4f: c = 8'h31;
      7'h50: c = 8'h32;
      7'h51: c = 8'h33;
      7'h52: c = 8'h30;
      7'h53: c = 8'h2e;
      7'h73: c = 8'h5c;
      7'h7d: c = 8'h5c;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] shift_char(input logic [6:0] code);
    logic [7:0] c;
    case (code)
      7'h02: c = 8'h21;
      7'h03: c = 8'h40;
      7'h04: c = 8'h23;
      7'h05: c = 8'h24;
      7'h06: c = 8'h25;
      7'h07: c = 8'h5e;
      7'h08: c = 8'h26;
      7'h09: c = 8'h2a;
      7'h0a: c = 8'h28;
      7'h0b: c = 8'h29;
      7'h0c: c = 8'h5f;
      7'h0d: c = 8'h2b;
      7'h1a: c = 8'h7b;
      7'h1b: c = 8'h7d;
      7'h27: c = 8'h3a;
      7'h28: c = 8'h22;
      7'h2b: c = 8'h7d;
      7'h33: c = 8'h3c;
      7'h34: c = 8'h3e;
      7'h35: c = 8'h3f;
      7'h73: c = 8'h5f;
      7'h7d: c = 8'h7c;
      default: c = plain_char(code);
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/kst_ram.sv -----
module kst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/kst_keymap.sv -----
module kst_keymap (
  input  logic [7:0] code,
  input  logic       shifted,
  input  logic       caps,
  output logic [7:0] ch
);

  logic [7:0] raw;
  logic       letter;

  always_comb begin
    if (code[7]) begin
      raw = 8'h00;
    end else if (shifted) begin
      raw = kst_pkg::shift_char(code[6:0]);
    end else begin
      raw = kst_pkg::plain_char(code[6:0]);
    end
  end

  assign letter = (raw >= kst_pkg::CHAR_UPPER_A) && (raw <= kst_pkg::CHAR_UPPER_Z);
  assign ch = (letter && (caps == shifted)) ? raw + kst_pkg::CASE_GAP : raw;

endmodule

// ----- rtl/kst_res_fifo.sv -----
module kst_res_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          wr_cnt,
  input  kst_pkg::res_t       wr0,
  input  kst_pkg::res_t       wr1,
  input  logic                stall,
  output logic                valid,
  output kst_pkg::res_t       rd_data,
  output logic                room2
);

  kst_pkg::res_t                   ent [kst_pkg::RES_DEPTH];
  logic [kst_pkg::RES_PTR_W-1:0]   rd_ptr;
  logic [kst_pkg::RES_PTR_W-1:0]   wr_ptr;
  logic [kst_pkg::RES_CNT_W-1:0]   cnt;
  logic                            rd;

  assign valid   = (cnt != '0);
  assign rd      = valid && !stall;
  assign rd_data = ent[rd_ptr];
  assign room2   = (cnt <= kst_pkg::RES_CNT_W'(kst_pkg::RES_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      wr_ptr <= wr_ptr + kst_pkg::RES_PTR_W'(wr_cnt);
      cnt    <= cnt + kst_pkg::RES_CNT_W'(wr_cnt) - kst_pkg::RES_CNT_W'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) begin
      ent[wr_ptr] <= wr0;
    end
    if (wr_cnt == 2'd2) begin
      ent[wr_ptr + 1'b1] <= wr1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (wr_cnt != 2'd0) |->
      (cnt + kst_pkg::RES_CNT_W'(wr_cnt)) <= kst_pkg::RES_CNT_W'(kst_pkg::RES_DEPTH))
    else $error("result buffer overflow");

endmodule

// ----- rtl/keyboard_scancode_translator.sv -----
// scan code set 1 to character translator with keyboard led command queue
// item channel: item_valid / item_stall with kind and scan_code; an idle pass
// (kind high) only lets the next queued command byte go out
// result channel: result_valid / result_stall with out_kind, out_value, last;
// an item gives zero, one or two results, last marks the final one
// config channel: cfg_valid / cfg_ready, cfg_index 0 is boot_leds, 1 is retry_limit
// throughput: one item a cycle, item_stall low; a lock key item stalls the next,
// as its led byte is the second queue write through the single queue ram write port
// a result is written into the result buffer at its item transfer and offered from there
// results leave one a cycle, result_stall low, through a four-entry buffer; when the
// receiver stalls, items are taken while the buffer has room for two more results
// the command queue sits in a synchronous ram, its head entry is read ahead
// from head_next, with forwarding of a write to the same entry
// reset, and a write of boot_leds, load 0xed and then the led value into the queue
// in the restart and pend states, with item_stall high and cfg_ready low meanwhile
module keyboard_scancode_translator #(
  parameter int CMD_QUEUE_DEPTH = kst_pkg::CMD_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic       kind,
  input  logic [7:0] scan_code,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_value,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [3:0] cfg_data
);

  localparam int HW = $clog2(CMD_QUEUE_DEPTH);
  localparam int CW = $clog2(CMD_QUEUE_DEPTH + 1);
  localparam logic [CW:0]   DEPTH_X = (CW + 1)'(CMD_QUEUE_DEPTH);
  localparam logic [HW-1:0] HEAD_LAST = HW'(CMD_QUEUE_DEPTH - 1);

  logic [1:0]    shift_bits;
  logic          ctrl_held;
  logic          alt_held;
  logic          escape_flag;
  logic [2:0]    led_bits;
  logic [2:0]    boot_leds;
  logic [3:0]    retry_limit;
  logic [HW-1:0] head;
  logic [CW-1:0] count;
  logic          awaiting_ack;
  logic [7:0]    pending_byte;
  logic [3:0]    retry_count;
  logic          restart;
  logic          pend;
  logic [HW-1:0] pend_addr;
  logic [7:0]    pend_data;
  logic          fwd_hit;
  logic [7:0]    fwd_data;

  logic [1:0]    shift_bits_next;
  logic          ctrl_held_next;
  logic          alt_held_next;
  logic          escape_flag_next;
  logic [2:0]    led_bits_next;
  logic [HW-1:0] head_next;
  logic [CW-1:0] count_next;
  logic          awaiting_ack_next;
  logic [7:0]    pending_byte_next;
  logic [3:0]    retry_count_next;

  logic          item_acc;
  logic          cfg_acc;
  logic          room2;
  logic          send;
  logic [HW-1:0] head1;
  logic [CW-1:0] count1;
  logic          awaiting1;
  logic [7:0]    pending1;
  logic [7:0]    rdata;
  logic [7:0]    head_byte;
  logic [7:0]    ch;
  logic          lock;
  logic          push1;
  logic          push2;
  logic [CW:0]   sum1;
  logic [CW:0]   sum2;
  logic [HW-1:0] tail1;
  logic [HW-1:0] tail2;
  logic          r1_v;
  logic [2:0]    r1_kind;
  logic [7:0]    r1_val;
  logic          we;
  logic [HW-1:0] waddr;
  logic [7:0]    wdata;
  logic [1:0]    wr_cnt;
  kst_pkg::res_t res0;
  kst_pkg::res_t res1;
  kst_pkg::res_t res_out;

  assign item_stall = restart || pend || !room2;
  assign item_acc   = item_valid && !item_stall;
  assign cfg_ready  = !restart && !pend;
  assign cfg_acc    = cfg_valid && cfg_ready;

  kst_ram #(
    .WIDTH (8),
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (head_next),
    .rdata (rdata)
  );

  assign head_byte = fwd_hit ? fwd_data : rdata;

  kst_keymap u_keymap (
    .code    (scan_code),
    .shifted (shift_bits != 2'b00),
    .caps    ((led_bits & kst_pkg::LED_CAPS) != 3'b000),
    .ch      (ch)
  );

  // send step at the start of the item
  always_comb begin
    send      = (count != '0) && !awaiting_ack;
    head1     = head;
    count1    = count;
    awaiting1 = awaiting_ack;
    pending1  = pending_byte;
    if (send) begin
      head1     = (head == HEAD_LAST) ? '0 : head + 1'b1;
      count1    = count - 1'b1;
      awaiting1 = 1'b1;
      pending1  = head_byte;
    end
  end

  always_comb begin
    shift_bits_next   = shift_bits;
    ctrl_held_next    = ctrl_held;
    alt_held_next     = alt_held;
    escape_flag_next  = escape_flag;
    led_bits_next     = led_bits;
    awaiting_ack_next = awaiting1;
    retry_count_next  = retry_count;
    lock              = 1'b0;
    r1_v              = 1'b0;
    r1_kind           = kst_pkg::KIND_CHAR;
    r1_val            = ch;
    if (kind == kst_pkg::ITEM_SCAN) begin
      r1_v = (ch != 8'h00);
      case (scan_code)
        kst_pkg::SC_ENTER: begin
          r1_v   = 1'b1;
          r1_val = kst_pkg::CHAR_LF;
        end
        kst_pkg::SC_BACKSPACE: begin
          r1_v   = 1'b1;
          r1_val = kst_pkg::CHAR_BS;
        end
        kst_pkg::SC_TAB: begin
          if (alt_held) begin
            r1_v    = 1'b1;
            r1_kind = kst_pkg::KIND_SWITCH;
            r1_val  = 8'h00;
          end
        end
        kst_pkg::SC_C_UP: begin
          if (ctrl_held) begin
            r1_v    = 1'b1;
            r1_kind = kst_pkg::KIND_BREAK;
            r1_val  = 8'h00;
          end
        end
        kst_pkg::SC_LSHIFT:    shift_bits_next = shift_bits | 2'b01;
        kst_pkg::SC_RSHIFT:    shift_bits_next = shift_bits | 2'b10;
        kst_pkg::SC_LSHIFT_UP: shift_bits_next = shift_bits & 2'b10;
        kst_pkg::SC_RSHIFT_UP: shift_bits_next = shift_bits & 2'b01;
        kst_pkg::SC_CTRL:      ctrl_held_next = 1'b1;
        kst_pkg::SC_CTRL_UP:   ctrl_held_next = 1'b0;
        kst_pkg::SC_ALT:       alt_held_next = 1'b1;
        kst_pkg::SC_ALT_UP:    alt_held_next = 1'b0;
        kst_pkg::SC_ESCAPE: begin
          escape_flag_next = !escape_flag;
          r1_v             = 1'b1;
          r1_kind          = kst_pkg::KIND_ESCAPE;
          r1_val           = {7'b0, !escape_flag};
        end
        kst_pkg::SC_CAPS: begin
          led_bits_next = led_bits ^ kst_pkg::LED_CAPS;
          lock          = 1'b1;
        end
        kst_pkg::SC_NUM: begin
          led_bits_next = led_bits ^ kst_pkg::LED_NUM;
          lock          = 1'b1;
        end
        kst_pkg::SC_SCROLL: begin
          led_bits_next = led_bits ^ kst_pkg::LED_SCROLL;
          lock          = 1'b1;
        end
        kst_pkg::BYTE_ACK: begin
          awaiting_ack_next = 1'b0;
          retry_count_next  = 4'd0;
        end
        kst_pkg::BYTE_RESEND: begin
          if (awaiting1 && (retry_count < retry_limit)) begin
            r1_v             = 1'b1;
            r1_kind          = kst_pkg::KIND_KBD;
            r1_val           = pending1;
            retry_count_next = retry_count + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // queue pushes, each dropped on its own when full
  always_comb begin
    sum1  = (CW + 1)'(head1) + (CW + 1)'(count1);
    sum2  = sum1 + 1'b1;
    tail1 = (sum1 >= DEPTH_X) ? HW'(sum1 - DEPTH_X) : HW'(sum1);
    tail2 = (sum2 >= DEPTH_X) ? HW'(sum2 - DEPTH_X) : HW'(sum2);
    push1 = lock && ((CW + 1)'(count1) < DEPTH_X);
    push2 = lock && (((CW + 1)'(count1) + 1'b1) < DEPTH_X);
    count_next = count1 + CW'(push1) + CW'(push2);
    pending_byte_next = pending1;
  end

  always_comb begin
    if (restart) begin
      head_next = '0;
    end else if (item_acc) begin
      head_next = head1;
    end else begin
      head_next = head;
    end
  end

  always_comb begin
    if (restart) begin
      we    = 1'b1;
      waddr = '0;
      wdata = kst_pkg::BYTE_SET_LEDS;
    end else if (pend) begin
      we    = 1'b1;
      waddr = pend_addr;
      wdata = pend_data;
    end else begin
      we    = item_acc && push1;
      waddr = tail1;
      wdata = kst_pkg::BYTE_SET_LEDS;
    end
  end

  always_comb begin
    res0 = send ? '{kind: kst_pkg::KIND_KBD, value: head_byte, last: !r1_v}
                : '{kind: r1_kind, value: r1_val, last: 1'b1};
    res1 = '{kind: r1_kind, value: r1_val, last: 1'b1};
    wr_cnt = item_acc ? (2'(send) + 2'(r1_v)) : 2'd0;
  end

  kst_res_fifo u_res (
    .clk     (clk),
    .rst     (rst),
    .wr_cnt  (wr_cnt),
    .wr0     (res0),
    .wr1     (res1),
    .stall   (result_stall),
    .valid   (result_valid),
    .rd_data (res_out),
    .room2   (room2)
  );

  assign out_kind  = res_out.kind;
  assign out_value = res_out.value;
  assign last      = res_out.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_bits   <= 2'b00;
      ctrl_held    <= 1'b0;
      alt_held     <= 1'b0;
      escape_flag  <= 1'b0;
      led_bits     <= 3'b000;
      boot_leds    <= 3'b000;
      retry_limit  <= kst_pkg::RETRY_LIMIT_RESET;
      head         <= '0;
      count        <= '0;
      awaiting_ack <= 1'b0;
      pending_byte <= 8'h00;
      retry_count  <= 4'd0;
      restart      <= 1'b1;
      pend         <= 1'b0;
      fwd_hit      <= 1'b0;
    end else begin
      fwd_hit <= we && (waddr == head_next);
      if (restart) begin
        restart      <= 1'b0;
        led_bits     <= boot_leds;
        head         <= '0;
        count        <= CW'(2);
        awaiting_ack <= 1'b0;
        pending_byte <= 8'h00;
        retry_count  <= 4'd0;
        pend         <= 1'b1;
      end else if (pend) begin
        pend <= 1'b0;
      end else if (item_acc) begin
        shift_bits   <= shift_bits_next;
        ctrl_held    <= ctrl_held_next;
        alt_held     <= alt_held_next;
        escape_flag  <= escape_flag_next;
        led_bits     <= led_bits_next;
        head         <= head1;
        count        <= count_next;
        awaiting_ack <= awaiting_ack_next;
        pending_byte <= pending_byte_next;
        retry_count  <= retry_count_next;
        pend         <= push2;
      end
      if (cfg_acc) begin
        if (cfg_index == kst_pkg::REG_BOOT_LEDS) begin
          boot_leds <= cfg_data[2:0];
          restart   <= 1'b1;
        end else begin
          retry_limit <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= wdata;
    if (restart) begin
      pend_addr <= HW'(1);
      pend_data <= {5'b0, boot_leds};
    end else if (item_acc) begin
      pend_addr <= tail2;
      pend_data <= {5'b0, led_bits_next};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (CW + 1)'(count) <= DEPTH_X)
    else $error("command queue count beyond depth");

  a_pend_blocks: assert property (@(posedge clk) disable iff (rst)
    pend |-> (item_stall && !cfg_ready))
    else $error("transfer taken while second queue write pending");

  a_send_awaits: assert property (@(posedge clk) disable iff (rst)
    (item_acc && send && !((kind == kst_pkg::ITEM_SCAN) && (scan_code == kst_pkg::BYTE_ACK)))
      |=> awaiting_ack)
    else $error("sent byte not awaiting ack");

  a_restart_load: assert property (@(posedge clk) disable iff (rst)
    restart |=> ((count == CW'(2)) && (head == '0) && pend))
    else $error("queue restart did not load two bytes");

endmodule
